@@ design/rtcm_pkg.sv @@
// Shared types, codes and byte conversions for the three-wire RTC register master.
// No dependencies; used by the engine and the top level.
package rtcm_pkg;

  localparam int unsigned ValueW = 8;
  localparam int unsigned BitCntW = 4;
  localparam int unsigned CfgIndexW = 2;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Read decode modes.
  localparam logic [1:0] DEC_RAW  = 2'd0;
  localparam logic [1:0] DEC_BCD  = 2'd1;
  localparam logic [1:0] DEC_HOUR = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_CE_SETUP    = 2'd1;

  localparam logic [ValueW-1:0] CMD_READ_BASE  = 8'h81;
  localparam logic [ValueW-1:0] CMD_WRITE_BASE = 8'h80;

  localparam logic [ValueW-1:0] HALF_PERIOD_RESET = 8'd1;
  localparam logic [ValueW-1:0] CE_SETUP_RESET    = 8'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETUP,
    PH_CMD,
    PH_WDATA,
    PH_RDATA
  } phase_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [4:0]        reg_index;
    logic [ValueW-1:0] write_value;
    logic              write_encode;
    logic [1:0]        read_decode;
    logic              data_pin_in;
  } item_t;

  typedef struct packed {
    logic              clk_pin;
    logic              data_pin_out;
    logic              data_pin_drive;
    logic              ce_pin;
    logic              busy_res;
    logic              done_res;
    logic              request_rejected;
    logic [ValueW-1:0] read_raw;
    logic [ValueW-1:0] read_value;
  } result_t;

  // Decimal to BCD. The tens digit comes from a reciprocal multiply, exact for
  // all 8-bit values; above 99 the tens quotient wraps into the high nibble.
  function automatic logic [ValueW-1:0] to_bcd(input logic [ValueW-1:0] v);
    logic [15:0] prod;
    logic [4:0]  tens;
    logic [7:0]  ones;
    prod = 16'(v) * 16'd205;
    tens = prod[15:11];
    ones = v - (8'(tens) * 8'd10);
    return {tens[3:0], ones[3:0]};
  endfunction

  function automatic logic [ValueW-1:0] decode_byte(input logic [ValueW-1:0] v,
                                                     input logic [1:0] mode);
    logic [ValueW-1:0] r;
    r = v;
    case (mode)
      DEC_BCD: begin
        r = ({4'd0, v[7:4]} * 8'd10) + {4'd0, v[3:0]};
      end
      DEC_HOUR: begin
        // In 12-hour mode bit 5 is the PM flag and counts as twelve hours.
        if (v[7]) begin
          r = {4'd0, v[3:0]} + (v[4] ? 8'd10 : 8'd0) + (v[5] ? 8'd12 : 8'd0);
        end else begin
          r = {4'd0, v[3:0]} + ({6'd0, v[5:4]} * 8'd10);
        end
      end
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

@@ design/rtcm_engine.sv @@
// Bus sequencer of the RTC register master: phase, tick and bit counters,
// shift registers and the last read byte. Depends on rtcm_pkg.
module rtcm_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  rtcm_pkg::item_t           item,
  input  logic [rtcm_pkg::ValueW-1:0] half_period_ticks,
  input  logic [rtcm_pkg::ValueW-1:0] ce_setup_ticks,
  output rtcm_pkg::result_t         result
);
  import rtcm_pkg::*;

  phase_t              phase, phase_next;
  logic [ValueW-1:0]   tick_count, tick_count_next;
  logic [BitCntW-1:0]  bit_count, bit_count_next;
  logic [ValueW-1:0]   command_shift, command_shift_next;
  logic [ValueW-1:0]   data_shift, data_shift_next;
  logic                is_read, is_read_next;
  logic [1:0]          decode_mode, decode_mode_next;
  logic [ValueW-1:0]   last_read, last_read_next;
  logic [ValueW-1:0]   last_value, last_value_next;
  logic                clk_high, clk_high_next;

  logic                is_req;
  logic                done;
  logic [ValueW-1:0]   half;
  logic [ValueW-1:0]   tick_inc;
  logic [BitCntW-1:0]  bit_inc;

  assign is_req   = (item.req_type == REQ_READ) || (item.req_type == REQ_WRITE);
  assign half     = (half_period_ticks == '0) ? ValueW'(1) : half_period_ticks;
  assign tick_inc = tick_count + ValueW'(1);
  assign bit_inc  = bit_count + BitCntW'(1);

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_count_next     = bit_count;
    command_shift_next = command_shift;
    data_shift_next    = data_shift;
    is_read_next       = is_read;
    decode_mode_next   = decode_mode;
    last_read_next     = last_read;
    last_value_next    = last_value;
    clk_high_next      = clk_high;
    done               = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (is_req) begin
          is_read_next       = (item.req_type == REQ_READ);
          decode_mode_next   = item.read_decode;
          command_shift_next = ((item.req_type == REQ_READ) ? CMD_READ_BASE : CMD_WRITE_BASE)
                               | {2'b00, item.reg_index, 1'b0};
          data_shift_next    = item.write_encode ? to_bcd(item.write_value)
                                                 : item.write_value;
          tick_count_next    = '0;
          if (ce_setup_ticks == '0) begin
            phase_next     = PH_CMD;
            bit_count_next = '0;
            clk_high_next  = 1'b0;
          end else begin
            phase_next = PH_SETUP;
          end
        end
      end
      PH_SETUP: begin
        tick_count_next = tick_inc;
        if (tick_inc >= ce_setup_ticks) begin
          phase_next      = PH_CMD;
          tick_count_next = '0;
          bit_count_next  = '0;
          clk_high_next   = 1'b0;
        end
      end
      PH_CMD, PH_WDATA, PH_RDATA: begin
        tick_count_next = tick_inc;
        if (tick_inc >= half) begin
          tick_count_next = '0;
          if (!clk_high) begin
            // Read data is sampled on the tick that raises the clock.
            if (phase == PH_RDATA) begin
              data_shift_next = {item.data_pin_in, data_shift[ValueW-1:1]};
            end
            clk_high_next = 1'b1;
          end else begin
            clk_high_next  = 1'b0;
            bit_count_next = bit_inc;
            if (phase == PH_CMD) begin
              command_shift_next = command_shift >> 1;
            end else if (phase == PH_WDATA) begin
              data_shift_next = data_shift >> 1;
            end
            if (bit_inc[BitCntW-1]) begin
              if (phase == PH_CMD) begin
                bit_count_next = '0;
                if (is_read) begin
                  data_shift_next = '0;
                  phase_next      = PH_RDATA;
                end else begin
                  phase_next = PH_WDATA;
                end
              end else begin
                if (phase == PH_RDATA) begin
                  last_read_next  = data_shift;
                  last_value_next = decode_byte(data_shift, decode_mode);
                end
                phase_next     = PH_IDLE;
                bit_count_next = '0;
                done           = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
        bit_count_next  = '0;
        clk_high_next   = 1'b0;
      end
    endcase
  end

  // Pin levels follow the state after this tick's update.
  always_comb begin
    result                  = '0;
    result.busy_res         = (phase_next != PH_IDLE);
    result.done_res         = done;
    result.request_rejected = is_req && (phase != PH_IDLE);
    result.read_raw         = last_read_next;
    result.read_value       = last_value_next;
    unique case (phase_next)
      PH_SETUP: begin
        result.ce_pin         = 1'b1;
        result.data_pin_drive = 1'b1;
      end
      PH_CMD: begin
        result.ce_pin         = 1'b1;
        result.data_pin_drive = 1'b1;
        result.clk_pin        = clk_high_next;
        result.data_pin_out   = command_shift_next[0];
      end
      PH_WDATA: begin
        result.ce_pin         = 1'b1;
        result.data_pin_drive = 1'b1;
        result.clk_pin        = clk_high_next;
        result.data_pin_out   = data_shift_next[0];
      end
      PH_RDATA: begin
        result.ce_pin  = 1'b1;
        result.clk_pin = clk_high_next;
      end
      default: begin
        result.ce_pin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_count     <= '0;
      command_shift <= '0;
      data_shift    <= '0;
      is_read       <= 1'b0;
      decode_mode   <= DEC_RAW;
      last_read     <= '0;
      last_value    <= '0;
      clk_high      <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_count     <= bit_count_next;
      command_shift <= command_shift_next;
      data_shift    <= data_shift_next;
      is_read       <= is_read_next;
      decode_mode   <= decode_mode_next;
      last_read     <= last_read_next;
      last_value    <= last_value_next;
      clk_high      <= clk_high_next;
    end
  end

endmodule

@@ design/three_wire_rtc_register_master.sv @@
// Top level of the three-wire RTC register master: input register, config
// registers, sequencer and output register. Depends on rtcm_pkg and rtcm_engine.
//
// Each input word is one timing tick, optionally carrying a read or write
// request, and produces exactly one result word with the bus pin levels and
// status after that tick. A word passes through one input register and one
// output register before its result word is presented. A new word is accepted
// in every cycle as long as the output side keeps taking results; the sequencer
// state is updated once per word. Bus timing is counted in words, not clock
// cycles: chip enable leads the first bit by ce_setup_ticks words and each
// serial clock half lasts half_period_ticks words. Configuration writes are
// taken at any time but should only be made while no transfer is running.
module three_wire_rtc_register_master (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      req_type,
  input  logic [4:0]                      reg_index,
  input  logic [rtcm_pkg::ValueW-1:0]     write_value,
  input  logic                            write_encode,
  input  logic [1:0]                      read_decode,
  input  logic                            data_pin_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            clk_pin,
  output logic                            data_pin_out,
  output logic                            data_pin_drive,
  output logic                            ce_pin,
  output logic                            busy_res,
  output logic                            done_res,
  output logic                            request_rejected,
  output logic [rtcm_pkg::ValueW-1:0]     read_raw,
  output logic [rtcm_pkg::ValueW-1:0]     read_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rtcm_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [rtcm_pkg::ValueW-1:0]     cfg_data
);
  import rtcm_pkg::*;

  logic              stage_valid;
  item_t             stage_item;
  logic              advance;
  result_t           result;
  result_t           out_word;
  logic [ValueW-1:0] half_period_ticks;
  logic [ValueW-1:0] ce_setup_ticks;

  assign advance   = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
      ce_setup_ticks    <= CE_SETUP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HALF_PERIOD: half_period_ticks <= cfg_data;
        CFG_CE_SETUP:    ce_setup_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= '{req_type:     req_type,
                      reg_index:    reg_index,
                      write_value:  write_value,
                      write_encode: write_encode,
                      read_decode:  read_decode,
                      data_pin_in:  data_pin_in};
    end
  end

  rtcm_engine u_engine (
    .clk               (clk),
    .rst               (rst),
    .step              (advance),
    .item              (stage_item),
    .half_period_ticks (half_period_ticks),
    .ce_setup_ticks    (ce_setup_ticks),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  assign clk_pin          = out_word.clk_pin;
  assign data_pin_out     = out_word.data_pin_out;
  assign data_pin_drive   = out_word.data_pin_drive;
  assign ce_pin           = out_word.ce_pin;
  assign busy_res         = out_word.busy_res;
  assign done_res         = out_word.done_res;
  assign request_rejected = out_word.request_rejected;
  assign read_raw         = out_word.read_raw;
  assign read_value       = out_word.read_value;

endmodule

@@ design/rtcm_checker.sv @@
// Port-level checks on the RTC register master's result words, and the bind
// that attaches them to the top level. Depends on three_wire_rtc_register_master.
module rtcm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       clk_pin,
  input logic       data_pin_out,
  input logic       data_pin_drive,
  input logic       ce_pin,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_raw
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_raw) && $stable(done_res))
    else $error("stalled result word changed");

  // Chip enable is high exactly while a transfer runs.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ce_pin == busy_res))
    else $error("chip enable disagrees with busy");

  // The completing word shows the bus back at rest.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && !clk_pin && !data_pin_drive)
    else $error("bus not idle on done");

  // A released data line carries no driven level.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_pin_drive |-> !data_pin_out)
    else $error("data level set while released");

endmodule

bind three_wire_rtc_register_master rtcm_checker u_rtcm_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .clk_pin        (clk_pin),
  .data_pin_out   (data_pin_out),
  .data_pin_drive (data_pin_drive),
  .ce_pin         (ce_pin),
  .busy_res       (busy_res),
  .done_res       (done_res),
  .read_raw       (read_raw)
);
